>>> rtl/hex_grid_pixel_hit_test_unit_defines.svh
// ----------------------------------------------------------------------------
// Hex grid pixel hit test: assertion macros
// Shared concurrent assertion forms used by the hit test RTL.
// ----------------------------------------------------------------------------
`ifndef HEX_GRID_PIXEL_HIT_TEST_UNIT_DEFINES_SVH
`define HEX_GRID_PIXEL_HIT_TEST_UNIT_DEFINES_SVH

// Antecedent implies consequent in the same cycle.
`define HGH_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("hex grid hit test: same-cycle check failed");

// Antecedent implies consequent in the following cycle.
`define HGH_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("hex grid hit test: next-cycle check failed");

`endif

>>> rtl/hgh_pkg.sv
// ----------------------------------------------------------------------------
// Hex grid hit test package
// Shared widths, register indexes and controller/datapath interface types.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package hgh_pkg;

  // Default grid size.
  localparam int DEF_COLUMNS = 15;
  localparam int DEF_ROWS    = 11;

  // Band index of row pair zero, doubled for the half-pixel coordinate frame.
  localparam int BAND_TOP    = 5;
  localparam int BAND_TOP2   = 2 * BAND_TOP;

  // Field widths.
  localparam int COORD_W = 13;
  localparam int ORIG_W  = 13;
  localparam int STEP_W  = 10;
  localparam int IDX_W   = 6;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 13;

  // Doubled positions and differences; covers a 64 by 64 grid.
  localparam int POS_W = 20;
  localparam int SQ_W  = 2 * POS_W;
  localparam int SUM_W = SQ_W + 1;
  localparam int LIM_W = 2 * (STEP_W + 1);

  // Register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_X2 = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_Y2 = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_COL_STEP  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_BAND_STEP = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_EVEN_SX   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_EVEN_SY   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_RADIUS    = 3'd6;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic             load;     // capture a new point and rewind the scan
    logic             issue;    // send the current cell into the pipeline
    logic             wrap;     // current cell is the last row of its column
    logic             capture;  // record the cell that just tested inside
    logic [IDX_W-1:0] col;
    logic [IDX_W-1:0] row;
  } hgh_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic neg;   // captured point has a negative coordinate
    logic hit;   // the cell at the end of the pipeline contains the point
    logic busy;  // cells are still in flight
  } hgh_sts_t;

endpackage

>>> rtl/hgh_dp.sv
// ----------------------------------------------------------------------------
// Hex grid hit test datapath
// Configuration registers, centre accumulators, and a two-stage
// difference/square pipeline with a squared-radius compare.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module hgh_dp
  import hgh_pkg::*;
(
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [CFG_IDX_W-1:0]         cfg_idx_i,
  input  logic [CFG_DATA_W-1:0]        cfg_wdata_i,
  input  logic signed [COORD_W-1:0]    px_i,
  input  logic signed [COORD_W-1:0]    py_i,
  input  hgh_cmd_t                     cmd_i,
  output hgh_sts_t                     sts_o,
  output logic                         hit_o,
  output logic [IDX_W-1:0]             cell_column_o,
  output logic [IDX_W-1:0]             cell_row_o
);

  logic [ORIG_W-1:0]        ox2_q, oy2_q;
  logic [STEP_W-1:0]        cs_q, bs_q, rad_q;
  logic signed [STEP_W-1:0] esx_q, esy_q;
  logic [LIM_W-1:0]         lim_q;

  logic [COORD_W-2:0]       px_q, py_q;
  logic                     neg_q;
  logic signed [POS_W-1:0]  colx_q, band_q;

  logic                     va_q, vb_q;
  logic signed [POS_W-1:0]  dx_q, dy_q;
  logic [IDX_W-1:0]         col_a_q, row_a_q, col_b_q, row_b_q;
  logic [SQ_W-1:0]          sqx_q, sqy_q;

  logic                     res_hit_q;
  logic [IDX_W-1:0]         res_col_q, res_row_q;

  logic signed [POS_W-1:0]  x2, y2, esx2, esy2, cs2, bs2, band_top, cx2, cy2;
  logic signed [SQ_W-1:0]   sqx_d, sqy_d;
  logic [SUM_W-1:0]         sum;
  logic                     even_row;
  logic [STEP_W:0]          rad2;

  assign x2       = POS_W'({px_q, 1'b0});
  assign y2       = POS_W'({py_q, 1'b0});
  assign esx2     = POS_W'(esx_q) <<< 1;
  assign esy2     = POS_W'(esy_q) <<< 1;
  assign cs2      = POS_W'({cs_q, 1'b0});
  assign bs2      = POS_W'({bs_q, 1'b0});
  assign band_top = POS_W'(oy2_q) + POS_W'(bs_q) * POS_W'(BAND_TOP2);
  assign even_row = ~cmd_i.row[0];
  assign cx2      = colx_q + (even_row ? esx2 : '0);
  assign cy2      = band_q + (even_row ? esy2 : '0);
  assign sqx_d    = dx_q * dx_q;
  assign sqy_d    = dy_q * dy_q;
  assign sum      = SUM_W'(sqx_q) + SUM_W'(sqy_q);
  assign rad2     = {rad_q, 1'b0};

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ox2_q <= '0;
      oy2_q <= '0;
      cs_q  <= '0;
      bs_q  <= '0;
      esx_q <= '0;
      esy_q <= '0;
      rad_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_ORIGIN_X2: ox2_q <= cfg_wdata_i[ORIG_W-1:0];
        CFG_ORIGIN_Y2: oy2_q <= cfg_wdata_i[ORIG_W-1:0];
        CFG_COL_STEP:  cs_q  <= cfg_wdata_i[STEP_W-1:0];
        CFG_BAND_STEP: bs_q  <= cfg_wdata_i[STEP_W-1:0];
        CFG_EVEN_SX:   esx_q <= cfg_wdata_i[STEP_W-1:0];
        CFG_EVEN_SY:   esy_q <= cfg_wdata_i[STEP_W-1:0];
        CFG_RADIUS:    rad_q <= cfg_wdata_i[STEP_W-1:0];
        default: ;
      endcase
    end
  end

  // Pipeline valid flags.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
      vb_q <= 1'b0;
    end else if (cmd_i.load) begin
      va_q <= 1'b0;
      vb_q <= 1'b0;
    end else begin
      va_q <= cmd_i.issue;
      vb_q <= va_q;
    end
  end

  // Point, accumulators, pipeline payload and result.
  always_ff @(posedge clk_i) begin
    // The squared limit follows the radius register; it is only read well after a load.
    lim_q   <= LIM_W'(rad2) * LIM_W'(rad2);
    dx_q    <= x2 - cx2;
    dy_q    <= y2 - cy2;
    col_a_q <= cmd_i.col;
    row_a_q <= cmd_i.row;
    sqx_q   <= SQ_W'(sqx_d);
    sqy_q   <= SQ_W'(sqy_d);
    col_b_q <= col_a_q;
    row_b_q <= row_a_q;
    if (cmd_i.load) begin
      px_q      <= px_i[COORD_W-2:0];
      py_q      <= py_i[COORD_W-2:0];
      neg_q     <= px_i[COORD_W-1] | py_i[COORD_W-1];
      colx_q    <= POS_W'(ox2_q);
      band_q    <= band_top;
      res_hit_q <= 1'b0;
      res_col_q <= '0;
      res_row_q <= '0;
    end else begin
      if (cmd_i.issue) begin
        if (cmd_i.wrap) begin
          colx_q <= colx_q + cs2;
          band_q <= band_top;
        end else if (cmd_i.row[0]) begin
          // Moving from an odd row to the next even row drops one band.
          band_q <= band_q - bs2;
        end
      end
      if (cmd_i.capture) begin
        res_hit_q <= 1'b1;
        res_col_q <= col_b_q;
        res_row_q <= row_b_q;
      end
    end
  end

  assign sts_o.neg  = neg_q;
  assign sts_o.hit  = vb_q && (sum <= SUM_W'(lim_q));
  assign sts_o.busy = va_q | vb_q;

  assign hit_o         = res_hit_q;
  assign cell_column_o = res_col_q;
  assign cell_row_o    = res_row_q;

endmodule

>>> rtl/hgh_ctrl.sv
// ----------------------------------------------------------------------------
// Hex grid hit test controller
// One-hot state machine and cell counters that sequence the grid scan.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module hgh_ctrl
  import hgh_pkg::*;
#(
  parameter int COLUMNS = DEF_COLUMNS,
  parameter int ROWS    = DEF_ROWS
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  output logic     out_valid_o,
  input  logic     out_stall_i,
  input  hgh_sts_t sts_i,
  output hgh_cmd_t cmd_o
);

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_SCAN  = 4'b0010,
    ST_DRAIN = 4'b0100,
    ST_DONE  = 4'b1000
  } state_e;

  state_e           state_q, state_d;
  logic [IDX_W-1:0] col_q, col_d, row_q, row_d;
  logic             last_row, last_cell, issue, capture;

  assign last_row  = (row_q == IDX_W'(ROWS - 1));
  assign last_cell = last_row && (col_q == IDX_W'(COLUMNS - 1));

  always_comb begin
    state_d = state_q;
    col_d   = col_q;
    row_d   = row_q;
    issue   = 1'b0;
    capture = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          state_d = ST_SCAN;
          col_d   = '0;
          row_d   = '0;
        end
      end
      ST_SCAN: begin
        if (sts_i.neg) begin
          state_d = ST_DONE;
        end else if (sts_i.hit) begin
          capture = 1'b1;
          state_d = ST_DONE;
        end else begin
          issue = 1'b1;
          if (last_cell) begin
            state_d = ST_DRAIN;
          end else if (last_row) begin
            row_d = '0;
            col_d = col_q + 1'b1;
          end else begin
            row_d = row_q + 1'b1;
          end
        end
      end
      ST_DRAIN: begin
        if (sts_i.hit) begin
          capture = 1'b1;
          state_d = ST_DONE;
        end else if (!sts_i.busy) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_stall_i) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      col_q   <= '0;
      row_q   <= '0;
    end else begin
      state_q <= state_d;
      col_q   <= col_d;
      row_q   <= row_d;
    end
  end

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = (state_q == ST_DONE);

  assign cmd_o.load    = (state_q == ST_IDLE) && in_valid_i;
  assign cmd_o.issue   = issue;
  assign cmd_o.wrap    = last_row;
  assign cmd_o.capture = capture;
  assign cmd_o.col     = col_q;
  assign cmd_o.row     = row_q;

endmodule

>>> rtl/hex_grid_pixel_hit_test_unit.sv
// ----------------------------------------------------------------------------
// Hex grid pixel hit test unit
// Finds the first cell of a staggered hexagon grid whose centre lies within
// the hit radius of a pointer position.
// ----------------------------------------------------------------------------
// Usage. A pointer position (px_i, py_i) arrives as one beat on the input
// channel (in_valid_i / in_stall_o) and produces exactly one result beat on
// the output channel (out_valid_o / out_stall_i) carrying hit_o, the column
// and the row of the first matching cell, or zeros on a miss.
// The grid is set up through the write port (cfg_we_i, cfg_idx_i,
// cfg_wdata_i); the user must do this only while the unit is idle, which
// the block itself does not enforce. Writes to index seven are dropped.
// Cells are scanned column by column, rows inner, one cell per cycle through
// a two-stage difference and square pipeline. The scan stops at the first
// cell found inside; a point with a negative coordinate issues no cells and
// reports a miss. One point is handled at a time: in_stall_o is high from
// acceptance until the result beat is taken. While the receiver stalls the
// result is held steady in its registers. Reset clears the configuration
// to zero and returns the unit to idle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module hex_grid_pixel_hit_test_unit
  import hgh_pkg::*;
#(
  parameter int COLUMNS = DEF_COLUMNS,
  parameter int ROWS    = DEF_ROWS
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  // Configuration write port.
  input  logic                      cfg_we_i,
  input  logic [CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [CFG_DATA_W-1:0]     cfg_wdata_i,
  // Input channel.
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  logic signed [COORD_W-1:0] px_i,
  input  logic signed [COORD_W-1:0] py_i,
  // Output channel.
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output logic                      hit_o,
  output logic [IDX_W-1:0]          cell_column_o,
  output logic [IDX_W-1:0]          cell_row_o
);

`include "hex_grid_pixel_hit_test_unit_defines.svh"

  hgh_cmd_t cmd;
  hgh_sts_t sts;

  // The controller owns the scan order and the handshakes.
  hgh_ctrl #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // The datapath walks the cell centres and tests each against the point.
  hgh_dp u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .px_i          (px_i),
    .py_i          (py_i),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .hit_o         (hit_o),
    .cell_column_o (cell_column_o),
    .cell_row_o    (cell_row_o)
  );

  // A result is never pending while a new point can be taken.
  `HGH_ASSERT_IMPL(a_one_in_flight, clk_i, rst_ni, !in_stall_o, !out_valid_o)
  // A reported hit names a cell inside the grid.
  `HGH_ASSERT_IMPL(a_hit_in_grid, clk_i, rst_ni, out_valid_o && hit_o, (cell_column_o <= IDX_W'(COLUMNS - 1)) && (cell_row_o <= IDX_W'(ROWS - 1)))
  // A miss reports cell zero.
  `HGH_ASSERT_IMPL(a_miss_zero, clk_i, rst_ni, out_valid_o && !hit_o, (cell_column_o == '0) && (cell_row_o == '0))
  // A taken result beat is never repeated.
  `HGH_ASSERT_NEXT(a_single_beat, clk_i, rst_ni, out_valid_o && !out_stall_i, !out_valid_o)

endmodule
